>>> rtl/core/chained_hash_table_engine_core_defines.svh
// Assertion macros for the hash table core
`ifndef CHAINED_HASH_TABLE_ENGINE_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_CORE_DEFINES_SVH

// Check that an antecedent implies a consequent on the same edge
`define CHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that an antecedent implies a consequent on the next edge
`define CHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/cht_pkg.sv
package cht_pkg;
	localparam int BUCKETS = 32;
	localparam int ENTRIES = 256;
	localparam int KEY_BITS = 32;
	localparam int VALUE_BITS = 32;
	localparam int NODE_W = $clog2(ENTRIES);
	localparam int LINK_W = NODE_W + 1;
	localparam int BKT_W = $clog2(BUCKETS);
	localparam int CNT_W = 9;
	localparam int STEP_W = $clog2(ENTRIES) + 1;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_FIND = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_REPLACED = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_FOUND = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_DELETED = 3'd5;
	localparam logic [2:0] ST_FULL = 3'd6;

	localparam logic [0:0] REG_BUCKET_COUNT = 1'd0;
	localparam logic [0:0] REG_REPLACE = 1'd1;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(ENTRIES);

	typedef struct packed {
		logic [1:0] mode;
		logic [31:0] key;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] value_out;
		logic [8:0] element_count;
	} out_item_t;

	typedef struct packed {
		logic we;
		logic [NODE_W-1:0] addr;
		logic [KEY_BITS-1:0] key;
		logic [VALUE_BITS-1:0] value;
		logic [LINK_W-1:0] next;
	} node_wr_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [VALUE_BITS-1:0] value;
		logic [LINK_W-1:0] next;
	} node_rd_t;
endpackage

>>> rtl/core/chained_hash_table_engine_core.sv
// Channel | Direction | Handshake      | Payload
// in      | input     | valid / stall  | in_item_t   (mode, key, value)
// out     | output    | valid / stall  | out_item_t  (status, value_out, element_count)
// cfg     | input     | valid / ready  | index, data
// One item at a time: the 32-step remainder loop sets the floor on the time from transfer
// to result, and each chain node visited adds a read.
// Reset sets every chain head to null, clears the element count and sets the pool low mark to full.
// Output stall holds the result register; a new item is taken once it is free.
`include "chained_hash_table_engine_core_defines.svh"
module chained_hash_table_engine_core
	import cht_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [5:0] cfg_data
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_HEAD = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_CMP = 3'd4;

	logic [2:0] state_q;
	logic [5:0] bcount_q;
	logic replace_q;
	in_item_t item_q;
	logic [BKT_W-1:0] bkt_q;
	logic [LINK_W-1:0] head_q [BUCKETS];
	logic [LINK_W-1:0] cur_q, prev_q;
	logic [STEP_W-1:0] steps_q;
	logic [CNT_W-1:0] count_q;
	logic [5:0] rem_q;
	logic [5:0] nb;
	logic [4:0] bit_q;
	logic hit;
	node_rd_t rd;
	node_wr_t wr;
	node_wr_t wr_fix;
	logic [KEY_BITS-1:0] prev_key_q;
	logic [VALUE_BITS-1:0] prev_val_q;
	logic rd_en;
	logic pop, push;
	logic [NODE_W-1:0] top_node;
	logic pool_empty;
	out_item_t res;
	logic finish;
	logic [LINK_W-1:0] head_cur;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign nb = (bcount_q == 6'd0) ? 6'd1 :
		(bcount_q > 6'(BUCKETS)) ? 6'(BUCKETS) : bcount_q;
	assign head_cur = head_q[bkt_q];
	assign rd_en = 1'b1;
	assign hit = (state_q == S_CMP) && (rd.key == item_q.key);

	cht_node_mem u_mem (
		.clk(clk), .rd_en(rd_en), .rd_addr(cur_q[NODE_W-1:0]), .rd_data(rd), .wr(wr_fix)
	);

	cht_free_pool u_pool (
		.clk(clk), .arst_n(arst_n), .pop(pop), .push(push),
		.push_node(cur_q[NODE_W-1:0]), .top_node(top_node), .empty(pool_empty)
	);

	always_comb begin
		wr = '0;
		pop = 1'b0;
		push = 1'b0;
		finish = 1'b0;
		res.status = ST_NOT_FOUND;
		res.value_out = '0;
		res.element_count = count_q;
		if (state_q == S_CMP && hit) begin
			finish = 1'b1;
			unique case (item_q.mode)
				MODE_INSERT: begin
					if (replace_q) begin
						wr = '{we: 1'b1, addr: cur_q[NODE_W-1:0], key: rd.key,
							value: item_q.value, next: rd.next};
						res.status = ST_REPLACED;
					end else begin
						res.status = ST_DUPLICATE;
					end
				end
				MODE_FIND: begin
					res.status = ST_FOUND;
					res.value_out = rd.value;
				end
				MODE_DELETE: begin
					res.status = ST_DELETED;
					push = 1'b1;
					res.element_count = count_q - CNT_W'(1);
					if (prev_q != NIL)
						wr = '{we: 1'b1, addr: prev_q[NODE_W-1:0], key: '0, value: '0,
							next: rd.next};
				end
				default: ;
			endcase
		end else if ((state_q == S_CMP
				&& (rd.next >= NIL || steps_q == STEP_W'(ENTRIES - 1)))
				|| (state_q == S_HEAD && head_cur >= NIL)) begin
			finish = 1'b1;
			if (item_q.mode == MODE_INSERT) begin
				if (pool_empty) begin
					res.status = ST_FULL;
				end else begin
					pop = 1'b1;
					wr = '{we: 1'b1, addr: top_node, key: item_q.key,
						value: item_q.value, next: head_cur};
					res.status = ST_INSERTED;
					res.element_count = count_q + CNT_W'(1);
				end
			end
		end
	end

	// The delete of a non-head node must rewrite only the next link of the previous node.
	always_comb begin
		wr_fix = wr;
		if (state_q == S_CMP && hit && item_q.mode == MODE_DELETE && prev_q != NIL) begin
			wr_fix.key = prev_key_q;
			wr_fix.value = prev_val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CMP) begin
			prev_key_q <= rd.key;
			prev_val_q <= rd.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bcount_q <= 6'd32;
			replace_q <= 1'b1;
			out_valid <= 1'b0;
			count_q <= '0;
			for (int i = 0; i < BUCKETS; i++) head_q[i] <= NIL;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_BUCKET_COUNT: bcount_q <= cfg_data;
					REG_REPLACE: replace_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						state_q <= S_HASH;
						rem_q <= '0;
						bit_q <= 5'd31;
					end
				end
				S_HASH: begin
					if ({rem_q[4:0], item_q.key[bit_q]} >= nb)
						rem_q <= {rem_q[4:0], item_q.key[bit_q]} - nb;
					else
						rem_q <= {rem_q[4:0], item_q.key[bit_q]};
					if (bit_q == 5'd0) state_q <= S_HEAD;
					bit_q <= bit_q - 5'd1;
				end
				S_HEAD: begin
					prev_q <= NIL;
					steps_q <= '0;
					if (finish) begin
						state_q <= S_IDLE;
						out_valid <= 1'b1;
						out_data <= res;
						count_q <= res.element_count;
						if (pop) head_q[bkt_q] <= LINK_W'(top_node);
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: state_q <= S_CMP;
				S_CMP: begin
					steps_q <= steps_q + STEP_W'(1);
					if (finish) begin
						state_q <= S_IDLE;
						out_valid <= 1'b1;
						out_data <= res;
						count_q <= res.element_count;
						if (pop) head_q[bkt_q] <= LINK_W'(top_node);
						if (push && prev_q == NIL) head_q[bkt_q] <= rd.next;
					end else begin
						prev_q <= cur_q;
						state_q <= S_WAIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !in_stall) item_q <= in_data;
		if (state_q == S_HASH && bit_q == 5'd0) begin
			if ({rem_q[4:0], item_q.key[0]} >= nb)
				bkt_q <= BKT_W'({rem_q[4:0], item_q.key[0]} - nb);
			else
				bkt_q <= BKT_W'({rem_q[4:0], item_q.key[0]});
		end
		if (state_q == S_HEAD) cur_q <= head_cur;
		else if (state_q == S_CMP && !finish) cur_q <= rd.next;
	end

	`CHT_ASSERT_IMP(a_one_port, clk, arst_n, out_valid, state_q == S_IDLE,
		"result pending while busy")
	`CHT_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid,
		"stalled result dropped")
	`CHT_ASSERT_IMP(a_pool, clk, arst_n, pop, !push, "pool pop and push together")
endmodule

>>> rtl/core/cht_node_mem.sv
module cht_node_mem
	import cht_pkg::*;
(
	input logic clk,
	input logic rd_en,
	input logic [NODE_W-1:0] rd_addr,
	output node_rd_t rd_data,
	input node_wr_t wr
);
	logic [KEY_BITS-1:0] key_mem [ENTRIES];
	logic [VALUE_BITS-1:0] val_mem [ENTRIES];
	logic [LINK_W-1:0] next_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			key_mem[wr.addr] <= wr.key;
			val_mem[wr.addr] <= wr.value;
			next_mem[wr.addr] <= wr.next;
		end
		if (rd_en) begin
			rd_data.key <= key_mem[rd_addr];
			rd_data.value <= val_mem[rd_addr];
			rd_data.next <= next_mem[rd_addr];
		end
	end
endmodule

>>> rtl/core/cht_free_pool.sv
module cht_free_pool
	import cht_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic pop,
	input logic push,
	input logic [NODE_W-1:0] push_node,
	output logic [NODE_W-1:0] top_node,
	output logic empty
);
	logic [NODE_W-1:0] stack_mem [ENTRIES];
	logic [CNT_W-1:0] free_q;
	logic [CNT_W-1:0] low_q;
	logic [NODE_W-1:0] rd_q;
	logic rd_init_q;
	logic [CNT_W-1:0] rd_idx;

	assign empty = (free_q == '0);
	assign rd_idx = free_q - CNT_W'(1);

	always_ff @(posedge clk) begin
		if (push) stack_mem[free_q[NODE_W-1:0]] <= push_node;
		rd_q <= stack_mem[rd_idx[NODE_W-1:0]];
	end

	// Slots below the lowest fill ever reached still hold their own index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= CNT_W'(ENTRIES);
			low_q <= CNT_W'(ENTRIES);
			rd_init_q <= 1'b1;
		end else begin
			rd_init_q <= (rd_idx < low_q);
			if (pop) begin
				free_q <= free_q - CNT_W'(1);
				if (rd_idx < low_q) low_q <= rd_idx;
			end else if (push) begin
				free_q <= free_q + CNT_W'(1);
			end
		end
	end

	assign top_node = rd_init_q ? rd_idx[NODE_W-1:0] : rd_q;
endmodule

>>> verif/chained_hash_table_engine_core_tb.sv
`default_nettype none

module chained_hash_table_engine_core_tb;
	import cht_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;

	chained_hash_table_engine_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// table mirror
	logic [LINK_W-1:0] tbl_head [BUCKETS];
	logic [31:0] tbl_key [ENTRIES];
	logic [31:0] tbl_value [ENTRIES];
	logic [LINK_W-1:0] tbl_next [ENTRIES];
	logic [LINK_W-1:0] pool_stack [ENTRIES];
	int unsigned pool_free;
	int unsigned held_count;
	logic [5:0] bucket_reg;
	logic replace_reg;

	out_item_t expected_results[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int transfers_in = 0;
	int transfers_out = 0;
	int unsigned cycles = 0;
	int status_seen [8];

	function automatic int unsigned bucket_for(logic [31:0] key);
		int unsigned n;
		n = bucket_reg;
		if (n == 0) n = 1;
		if (n > BUCKETS) n = BUCKETS;
		return key % n;
	endfunction

	function automatic int unsigned chain_find(int unsigned b, logic [31:0] key,
			output int unsigned prev);
		int unsigned cur;
		int unsigned p;
		int unsigned steps;
		cur = tbl_head[b];
		p = ENTRIES;
		steps = 0;
		while (cur < ENTRIES && steps < ENTRIES) begin
			if (tbl_key[cur] == key) begin
				prev = p;
				return cur;
			end
			p = cur;
			cur = tbl_next[cur];
			steps++;
		end
		prev = ENTRIES;
		return ENTRIES;
	endfunction

	function automatic out_item_t apply_op(in_item_t it);
		out_item_t r;
		int unsigned b;
		int unsigned prev;
		int unsigned node;
		r = '0;
		r.status = ST_NOT_FOUND;
		b = bucket_for(it.key);
		case (it.mode)
			MODE_INSERT: begin
				node = chain_find(b, it.key, prev);
				if (node != ENTRIES) begin
					if (replace_reg) begin
						tbl_value[node] = it.value;
						r.status = ST_REPLACED;
					end else begin
						r.status = ST_DUPLICATE;
					end
				end else if (pool_free == 0) begin
					r.status = ST_FULL;
				end else begin
					pool_free--;
					node = pool_stack[pool_free];
					tbl_key[node] = it.key;
					tbl_value[node] = it.value;
					tbl_next[node] = tbl_head[b];
					tbl_head[b] = LINK_W'(node);
					held_count++;
					r.status = ST_INSERTED;
				end
			end
			MODE_FIND: begin
				node = chain_find(b, it.key, prev);
				if (node != ENTRIES) begin
					r.status = ST_FOUND;
					r.value_out = tbl_value[node];
				end
			end
			MODE_DELETE: begin
				node = chain_find(b, it.key, prev);
				if (node != ENTRIES) begin
					if (prev == ENTRIES) tbl_head[b] = tbl_next[node];
					else tbl_next[prev] = tbl_next[node];
					tbl_next[node] = NIL;
					if (pool_free < ENTRIES) begin
						pool_stack[pool_free] = LINK_W'(node);
						pool_free++;
					end
					if (held_count > 0) held_count--;
					r.status = ST_DELETED;
				end
			end
			default: ;
		endcase
		r.element_count = 9'(held_count);
		return r;
	endfunction

	task automatic send_op(logic [1:0] mode, logic [31:0] key, logic [31:0] value);
		in_item_t it;
		it.mode = mode;
		it.key = key;
		it.value = value;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(apply_op(it));
		transfers_in++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [5:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_BUCKET_COUNT) bucket_reg = data;
		else replace_reg = data[0];
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		out_item_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("chained_hash_table_engine_core verification failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			transfers_out++;
			status_seen[out_data.status]++;
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer: status %0d", out_data.status);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (out_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_data.status);
					errors++;
				end
				if (out_data.value_out !== want.value_out) begin
					$error("value_out: expected %h, got %h", want.value_out,
						out_data.value_out);
					errors++;
				end
				if (out_data.element_count !== want.element_count) begin
					$error("element_count: expected %0d, got %0d",
						want.element_count, out_data.element_count);
					errors++;
				end
			end
		end
	end

	task automatic test_basic_ops();
		send_op(MODE_FIND, 32'h0, 32'h0);
		send_op(MODE_DELETE, 32'hFFFF_FFFF, 32'h0);
		send_op(MODE_INSERT, 32'h0, 32'hFFFF_FFFF);
		send_op(MODE_INSERT, 32'hFFFF_FFFF, 32'h0);
		send_op(MODE_INSERT, 32'h20, 32'h5A5A_A5A5);
		send_op(MODE_FIND, 32'h0, 32'h1234_5678);
		send_op(MODE_FIND, 32'hFFFF_FFFF, 32'h0);
		send_op(MODE_FIND, 32'h20, 32'h0);
		send_op(MODE_INSERT, 32'h0, 32'hA5A5_5A5A);
		send_op(MODE_FIND, 32'h0, 32'h0);
		send_op(MODE_UNUSED, 32'h20, 32'hFFFF_FFFF);
		send_op(MODE_DELETE, 32'h0, 32'h0);
		send_op(MODE_FIND, 32'h20, 32'h0);
		send_op(MODE_DELETE, 32'h0, 32'h0);
		write_reg(REG_REPLACE, 6'd0);
		send_op(MODE_INSERT, 32'h20, 32'h1111_1111);
		send_op(MODE_FIND, 32'h20, 32'h0);
		write_reg(REG_REPLACE, 6'd1);
	endtask

	task automatic test_bucket_extremes();
		write_reg(REG_BUCKET_COUNT, 6'd0);
		send_op(MODE_INSERT, 32'h7, 32'h77);
		send_op(MODE_FIND, 32'h20, 32'h0);
		send_op(MODE_FIND, 32'h7, 32'h0);
		write_reg(REG_BUCKET_COUNT, 6'd63);
		send_op(MODE_FIND, 32'h7, 32'h0);
		send_op(MODE_INSERT, 32'h27, 32'h99);
		write_reg(REG_BUCKET_COUNT, 6'd1);
		send_op(MODE_FIND, 32'h27, 32'h0);
		send_op(MODE_DELETE, 32'h7, 32'h0);
		write_reg(REG_BUCKET_COUNT, 6'd32);
	endtask

	task automatic test_pool_full();
		for (int i = 0; i < ENTRIES; i++) send_op(MODE_INSERT, 32'h1000 + i, $urandom());
		send_op(MODE_INSERT, 32'h8000_0001, 32'h1);
		send_op(MODE_INSERT, 32'h1005, 32'hDEAD_BEEF);
		write_reg(REG_REPLACE, 6'd0);
		send_op(MODE_INSERT, 32'h1006, 32'h2);
		send_op(MODE_INSERT, 32'h8000_0002, 32'h2);
		write_reg(REG_REPLACE, 6'd1);
		send_op(MODE_FIND, 32'h1005, 32'h0);
		for (int i = 0; i < ENTRIES; i++) send_op(MODE_DELETE, 32'h1000 + i, 32'h0);
	endtask

	function automatic logic [31:0] pick_key();
		if ($urandom_range(3) == 0) return $urandom();
		return $urandom_range(0, 95);
	endfunction

	task automatic random_burst(int count);
		logic [1:0] mode;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			mode = r < 45 ? MODE_INSERT : r < 75 ? MODE_FIND : r < 97 ? MODE_DELETE
				: MODE_UNUSED;
			send_op(mode, pick_key(), $urandom());
		end
	endtask

	task automatic test_random_traffic();
		logic [5:0] counts [5] = '{6'd7, 6'd1, 6'd32, 6'd13, 6'd63};
		int idle [4] = '{0, 87, 0, 6};
		int stall [4] = '{0, 0, 87, 6};
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_BUCKET_COUNT, counts[ph]);
			write_reg(REG_REPLACE, 6'($urandom_range(1)));
			send_idle_pct = idle[ph % 4];
			recv_stall_pct = stall[ph % 4];
			random_burst(18);
			in_valid <= 1'b0;
			while (expected_results.size() != 0) @(posedge clk);
			random_burst(18);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		for (int i = 0; i < BUCKETS; i++) tbl_head[i] = NIL;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_key[i] = '0;
			tbl_value[i] = '0;
			tbl_next[i] = NIL;
			pool_stack[i] = LINK_W'(i);
		end
		pool_free = ENTRIES;
		held_count = 0;
		bucket_reg = 6'd32;
		replace_reg = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_bucket_extremes();
		test_pool_full();
		test_random_traffic();

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		$display("%0d operations sent, %0d results checked across bucket counts 0..63,",
			transfers_in, transfers_out);
		$display("pool exhaustion and idle/stall mixes; status counts ins %0d rep %0d",
			status_seen[0], status_seen[1]);
		$display("dup %0d fnd %0d nf %0d del %0d full %0d",
			status_seen[2], status_seen[3], status_seen[4], status_seen[5],
			status_seen[6]);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("chained_hash_table_engine_core verification clean");
		end else begin
			$display("chained_hash_table_engine_core verification failed");
		end
		$finish;
	end
endmodule

`default_nettype wire
